// ----- design/csef_pkg.sv -----
// Package for the code span end finder: sizes, character codes, scan phase
// codes, the scan state and result structs and the state after a finished scan.
// No dependencies.
package csef_pkg;

    localparam int NEST_LIMIT = 8;
    localparam int DEPTH_BITS = 8;
    localparam int CHAR_BITS  = 21;
    localparam int NEST_BITS  = $clog2(NEST_LIMIT + 1);
    localparam int TOP_BITS   = (NEST_LIMIT > 1) ? $clog2(NEST_LIMIT) : 1;
    localparam int CFG_IDX_BITS = 2;
    localparam int STOP_BITS  = 7;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [NEST_BITS-1:0]  NEST_MAX  = NEST_BITS'(NEST_LIMIT);

    // character codes
    localparam logic [CHAR_BITS-1:0] CH_RBRACE    = 21'h7D;
    localparam logic [CHAR_BITS-1:0] CH_LBRACE    = 21'h7B;
    localparam logic [CHAR_BITS-1:0] CH_BACKTICK  = 21'h60;
    localparam logic [CHAR_BITS-1:0] CH_DOLLAR    = 21'h24;
    localparam logic [CHAR_BITS-1:0] CH_BACKSLASH = 21'h5C;
    localparam logic [CHAR_BITS-1:0] CH_NEWLINE   = 21'h0A;
    localparam logic [CHAR_BITS-1:0] CH_SLASH     = 21'h2F;
    localparam logic [CHAR_BITS-1:0] CH_STAR      = 21'h2A;
    localparam logic [CHAR_BITS-1:0] CH_SQUOTE    = 21'h27;
    localparam logic [CHAR_BITS-1:0] CH_DQUOTE    = 21'h22;
    localparam logic [CHAR_BITS-1:0] CH_SPACE     = 21'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB       = 21'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR        = 21'h0D;

    // quote kinds
    localparam logic [1:0] QK_NONE   = 2'd0;
    localparam logic [1:0] QK_SINGLE = 2'd1;
    localparam logic [1:0] QK_DOUBLE = 2'd2;

    // scan phases
    localparam logic [3:0] PH_SKIP        = 4'd0;
    localparam logic [3:0] PH_CODE        = 4'd1;
    localparam logic [3:0] PH_STOP1       = 4'd2;
    localparam logic [3:0] PH_STOP2       = 4'd3;
    localparam logic [3:0] PH_STRING      = 4'd4;
    localparam logic [3:0] PH_STRING_ESC  = 4'd5;
    localparam logic [3:0] PH_TMPL        = 4'd6;
    localparam logic [3:0] PH_TMPL_ESC    = 4'd7;
    localparam logic [3:0] PH_TMPL_DOLLAR = 4'd8;
    localparam logic [3:0] PH_HOLE        = 4'd9;
    localparam logic [3:0] PH_SLASH       = 4'd10;
    localparam logic [3:0] PH_LINE        = 4'd11;
    localparam logic [3:0] PH_BLOCK       = 4'd12;
    localparam logic [3:0] PH_BLOCK_STAR  = 4'd13;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_ENABLE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_FIRST  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_SECOND = 2'd2;

    typedef struct packed {
        logic                                  stop_enable;
        logic [STOP_BITS-1:0]                  stop_first_char;
        logic [STOP_BITS-1:0]                  stop_second_char;
    } stop_cfg_t;

    typedef struct packed {
        logic [3:0]                            phase;
        logic [1:0]                            quote_kind;
        logic [DEPTH_BITS-1:0]                 code_depth;
        logic                                  after_space_flag;
        logic                                  seen_code;
        logic [NEST_BITS-1:0]                  nest_level;
        logic [NEST_LIMIT-1:0][DEPTH_BITS-1:0] hole_depths;
        logic                                  string_in_hole;
    } scan_state_t;

    typedef struct packed {
        logic skipped;
        logic mark_before;
        logic mark_after;
        logic done_res;
        logic accepted;
        logic overflow;
    } scan_result_t;

    localparam scan_state_t SCAN_CLEAR = '{
        phase:            PH_SKIP,
        quote_kind:       QK_NONE,
        code_depth:       '0,
        after_space_flag: 1'b1,
        seen_code:        1'b0,
        nest_level:       '0,
        hole_depths:      '0,
        string_in_hole:   1'b0
    };

    localparam stop_cfg_t STOP_CFG_RESET = '{
        stop_enable:      1'b0,
        stop_first_char:  7'd111,
        stop_second_char: 7'd102
    };

endpackage

// ----- design/csef_step.sv -----
// Per-character scan step: next scan state and the result for one character.
// Pure combinational logic; depends on csef_pkg.
module csef_step
    import csef_pkg::*;
(
    input  scan_state_t            cur,
    input  stop_cfg_t              cfg,
    input  logic [CHAR_BITS-1:0]   char_code,
    input  logic                   end_of_input,
    output scan_state_t            nxt,
    output scan_result_t           res
);

    logic                  is_space;
    logic                  run_code;
    logic                  run_tmpl;
    logic                  do_push;
    logic                  done;
    logic                  ovf;
    logic                  acc;
    logic                  mb;
    logic                  ma;
    logic                  skp;
    logic [TOP_BITS-1:0]   top_idx;
    logic [DEPTH_BITS-1:0] hole_cur;
    logic [DEPTH_BITS-1:0] hole_dec;
    logic [CHAR_BITS-1:0]  stop_first;
    logic [CHAR_BITS-1:0]  stop_second;

    assign is_space = (char_code == CH_SPACE) ||
                      ((char_code >= CH_TAB) && (char_code <= CH_CR));
    assign stop_first  = CHAR_BITS'(cfg.stop_first_char);
    assign stop_second = CHAR_BITS'(cfg.stop_second_char);
    assign top_idx  = (cur.nest_level == '0) ? '0 : TOP_BITS'(cur.nest_level - 1'b1);
    assign hole_cur = cur.hole_depths[top_idx];
    assign hole_dec = (hole_cur != '0) ? hole_cur - 1'b1 : hole_cur;

    always_comb
    begin
        nxt      = cur;
        run_code = 1'b0;
        run_tmpl = 1'b0;
        do_push  = 1'b0;
        done     = 1'b0;
        ovf      = 1'b0;
        acc      = 1'b0;
        mb       = 1'b0;
        ma       = 1'b0;
        skp      = 1'b0;

        if (end_of_input)
        begin
            done = 1'b1;
        end
        else
        begin
            case (cur.phase)
                PH_CODE:
                begin
                    run_code = 1'b1;
                end
                PH_STOP1:
                begin
                    if (char_code == stop_second)
                    begin
                        nxt.phase = PH_STOP2;
                    end
                    else
                    begin
                        mb = 1'b1;
                        nxt.seen_code = 1'b1;
                        nxt.after_space_flag = 1'b0;
                        run_code = 1'b1;
                    end
                end
                PH_STOP2:
                begin
                    if (is_space || char_code == CH_RBRACE)
                    begin
                        done = 1'b1;
                        acc  = cur.seen_code;
                    end
                    else
                    begin
                        mb = 1'b1;
                        nxt.seen_code = 1'b1;
                        nxt.after_space_flag = 1'b0;
                        run_code = 1'b1;
                    end
                end
                PH_STRING:
                begin
                    if (char_code == CH_BACKSLASH)
                    begin
                        nxt.phase = PH_STRING_ESC;
                    end
                    else if ((cur.quote_kind == QK_SINGLE && char_code == CH_SQUOTE) ||
                             (cur.quote_kind == QK_DOUBLE && char_code == CH_DQUOTE))
                    begin
                        if (cur.string_in_hole)
                        begin
                            nxt.phase = PH_HOLE;
                        end
                        else
                        begin
                            nxt.phase = PH_CODE;
                            ma = 1'b1;
                            nxt.seen_code = 1'b1;
                        end
                    end
                    else if (char_code == CH_NEWLINE)
                    begin
                        // a newline inside a hole does nothing more there
                        if (cur.string_in_hole)
                        begin
                            nxt.phase = PH_HOLE;
                        end
                        else
                        begin
                            mb = 1'b1;
                            nxt.seen_code = 1'b1;
                            run_code = 1'b1;
                        end
                    end
                end
                PH_STRING_ESC:
                begin
                    nxt.phase = PH_STRING;
                end
                PH_TMPL:
                begin
                    run_tmpl = 1'b1;
                end
                PH_TMPL_ESC:
                begin
                    nxt.phase = PH_TMPL;
                end
                PH_TMPL_DOLLAR:
                begin
                    if (char_code == CH_LBRACE)
                    begin
                        nxt.hole_depths[top_idx] = DEPTH_BITS'(1);
                        nxt.phase = PH_HOLE;
                    end
                    else
                    begin
                        run_tmpl = 1'b1;
                    end
                end
                PH_HOLE:
                begin
                    if (char_code == CH_LBRACE)
                    begin
                        if (hole_cur == DEPTH_MAX)
                        begin
                            done = 1'b1;
                            ovf  = 1'b1;
                        end
                        else
                        begin
                            nxt.hole_depths[top_idx] = hole_cur + 1'b1;
                        end
                    end
                    else if (char_code == CH_RBRACE)
                    begin
                        nxt.hole_depths[top_idx] = hole_dec;
                        if (hole_dec == '0)
                        begin
                            nxt.phase = PH_TMPL;
                        end
                    end
                    else if (char_code == CH_SQUOTE || char_code == CH_DQUOTE)
                    begin
                        nxt.quote_kind = (char_code == CH_SQUOTE) ? QK_SINGLE : QK_DOUBLE;
                        nxt.string_in_hole = 1'b1;
                        nxt.phase = PH_STRING;
                    end
                    else if (char_code == CH_BACKTICK)
                    begin
                        do_push = 1'b1;
                    end
                end
                PH_SLASH:
                begin
                    if (char_code == CH_SLASH)
                    begin
                        nxt.phase = PH_LINE;
                    end
                    else if (char_code == CH_STAR)
                    begin
                        nxt.phase = PH_BLOCK;
                    end
                    else
                    begin
                        mb = 1'b1;
                        nxt.seen_code = 1'b1;
                        run_code = 1'b1;
                    end
                end
                PH_LINE:
                begin
                    if (char_code == CH_NEWLINE)
                    begin
                        mb = 1'b1;
                        nxt.seen_code = 1'b1;
                        run_code = 1'b1;
                    end
                end
                PH_BLOCK:
                begin
                    if (char_code == CH_STAR)
                    begin
                        nxt.phase = PH_BLOCK_STAR;
                    end
                end
                PH_BLOCK_STAR:
                begin
                    if (char_code == CH_SLASH)
                    begin
                        ma = 1'b1;
                        nxt.seen_code = 1'b1;
                        nxt.phase = PH_CODE;
                    end
                    else
                    begin
                        nxt.phase = (char_code == CH_STAR) ? PH_BLOCK_STAR : PH_BLOCK;
                    end
                end
                default:
                begin
                    // leading whitespace skip; unused codes fall back here too
                    nxt.phase = PH_SKIP;
                    if (is_space)
                    begin
                        skp = 1'b1;
                    end
                    else
                    begin
                        run_code = 1'b1;
                    end
                end
            endcase

            // template body, also re-entered after a lone '$'
            if (run_tmpl)
            begin
                nxt.phase = PH_TMPL;
                if (char_code == CH_BACKSLASH)
                begin
                    nxt.phase = PH_TMPL_ESC;
                end
                else if (char_code == CH_BACKTICK)
                begin
                    if (cur.nest_level <= NEST_BITS'(1))
                    begin
                        nxt.nest_level = '0;
                        nxt.phase = PH_CODE;
                        ma = 1'b1;
                        nxt.seen_code = 1'b1;
                    end
                    else
                    begin
                        nxt.nest_level = cur.nest_level - 1'b1;
                        nxt.phase = PH_HOLE;
                    end
                end
                else if (char_code == CH_DOLLAR)
                begin
                    nxt.phase = PH_TMPL_DOLLAR;
                end
            end

            // plain code, using the flags as updated above
            if (run_code)
            begin
                nxt.phase = PH_CODE;
                if (nxt.code_depth == '0 && char_code == CH_RBRACE)
                begin
                    done = 1'b1;
                    acc  = nxt.seen_code;
                end
                else if (cfg.stop_enable && nxt.code_depth == '0 &&
                         nxt.after_space_flag && char_code == stop_first)
                begin
                    nxt.phase = PH_STOP1;
                end
                else if (is_space)
                begin
                    nxt.after_space_flag = 1'b1;
                end
                else
                begin
                    nxt.after_space_flag = 1'b0;
                    if (char_code == CH_SQUOTE || char_code == CH_DQUOTE)
                    begin
                        nxt.quote_kind = (char_code == CH_SQUOTE) ? QK_SINGLE : QK_DOUBLE;
                        nxt.string_in_hole = 1'b0;
                        nxt.phase = PH_STRING;
                    end
                    else if (char_code == CH_BACKTICK)
                    begin
                        do_push = 1'b1;
                    end
                    else if (char_code == CH_SLASH)
                    begin
                        nxt.phase = PH_SLASH;
                    end
                    else if (char_code == CH_LBRACE && nxt.code_depth == DEPTH_MAX)
                    begin
                        done = 1'b1;
                        ovf  = 1'b1;
                    end
                    else
                    begin
                        if (char_code == CH_LBRACE)
                        begin
                            nxt.code_depth = nxt.code_depth + 1'b1;
                        end
                        else if (char_code == CH_RBRACE)
                        begin
                            nxt.code_depth = nxt.code_depth - 1'b1;
                        end
                        ma = 1'b1;
                        nxt.seen_code = 1'b1;
                    end
                end
            end

            // open a template, or overflow when the stack is full
            if (do_push)
            begin
                if (cur.nest_level >= NEST_MAX)
                begin
                    done = 1'b1;
                    ovf  = 1'b1;
                end
                else
                begin
                    nxt.hole_depths[TOP_BITS'(cur.nest_level)] = '0;
                    nxt.nest_level = cur.nest_level + 1'b1;
                    nxt.phase = PH_TMPL;
                end
            end
        end

        if (done)
        begin
            nxt = SCAN_CLEAR;
            skp = 1'b0;
            if (end_of_input || ovf)
            begin
                mb  = 1'b0;
                ma  = 1'b0;
                acc = 1'b0;
            end
        end

        res.skipped     = skp;
        res.mark_before = mb;
        res.mark_after  = ma;
        res.done_res    = done;
        res.accepted    = acc;
        res.overflow    = ovf;
    end

endmodule

// ----- design/code_span_end_finder.sv -----
// Top level of the code span end finder: configuration registers, scan state
// register and output result register. Depends on csef_pkg and csef_step.
//
// Usage:
// - Input channel (in_valid, in_stall, char_code, end_of_input) carries one
//   character per transaction; a transaction completes when in_valid is high
//   and in_stall is low at a rising edge of clk.
// - Output channel (out_valid, out_stall and the six flag ports) carries one
//   result per input transaction, in order.
// - Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   stop_enable (index 0), stop_first_char (1) and stop_second_char (2);
//   cfg_ready is always high and other indexes are ignored.
// - Each result is registered and is valid in the cycle after its input transaction.
// - Throughput: one character per cycle while in_stall is low, set by the combinational
//   scan step between the state register and the result register.
// - A stalled output holds its result; the input is stalled only while a
//   result is held and the receiver stalls, so items keep flowing otherwise.
// - Reset (rst_n low) empties the output, restores the configuration defaults
//   and returns the scan to leading whitespace skip. A finished scan (done)
//   clears the scan state so the next character starts a new scan.
module code_span_end_finder
    import csef_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CHAR_BITS-1:0]    char_code,
    input  logic                    end_of_input,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    skipped,
    output logic                    mark_before,
    output logic                    mark_after,
    output logic                    done_res,
    output logic                    accepted,
    output logic                    overflow,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [STOP_BITS-1:0]    cfg_data
);

    stop_cfg_t    cfg_reg;
    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t result_reg;
    scan_result_t result_next;
    logic         out_valid_reg;
    logic         in_accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    csef_step u_step (
        .cur          (state_reg),
        .cfg          (cfg_reg),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .nxt          (state_next),
        .res          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= STOP_CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STOP_ENABLE: cfg_reg.stop_enable      <= cfg_data[0];
                CFG_STOP_FIRST:  cfg_reg.stop_first_char  <= cfg_data;
                CFG_STOP_SECOND: cfg_reg.stop_second_char <= cfg_data;
                default:         cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // advance the scan on every input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SCAN_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign skipped     = result_reg.skipped;
    assign mark_before = result_reg.mark_before;
    assign mark_after  = result_reg.mark_after;
    assign done_res    = result_reg.done_res;
    assign accepted    = result_reg.accepted;
    assign overflow    = result_reg.overflow;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for code_span_end_finder: directed scans, nesting bounds and random
// source text under several stop word settings, checked against an in-bench scan predictor.
// Depends on csef_pkg and the design files.
module testbench
    import csef_pkg::*;
();

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 120;
    localparam int QUIET_LIMIT = 2000;

    typedef enum int {
        FR_WORD, FR_BLANK, FR_BRACES, FR_STRING, FR_TEMPLATE,
        FR_LINE_NOTE, FR_BLOCK_NOTE, FR_WIDE, FR_STOP_WORD, FR_SLASH
    } fragment_e;

    typedef enum int {RX_FREE, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_e;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CHAR_BITS-1:0]    char_code = '0;
    logic                    end_of_input = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    skipped;
    logic                    mark_before;
    logic                    mark_after;
    logic                    done_res;
    logic                    accepted;
    logic                    overflow;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [STOP_BITS-1:0]    cfg_data = '0;

    // predictor state and its copy of the registers
    scan_state_t  scan_now = SCAN_CLEAR;
    stop_cfg_t    stop_cfg = STOP_CFG_RESET;
    scan_result_t expected_flags[$];

    logic [CHAR_BITS-1:0] text[$];
    int mismatches = 0;
    int random_items = 0;
    int burst_left = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int rx_count = 0;
    rx_mode_e rx_mode = RX_FREE;

    code_span_end_finder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .skipped      (skipped),
        .mark_before  (mark_before),
        .mark_after   (mark_after),
        .done_res     (done_res),
        .accepted     (accepted),
        .overflow     (overflow),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic open_template();
        if (scan_now.nest_level >= NEST_MAX)
            return 1'b0;
        scan_now.hole_depths[scan_now.nest_level] = '0;
        scan_now.nest_level = scan_now.nest_level + 1'b1;
        scan_now.phase = PH_TMPL;
        return 1'b1;
    endfunction

    // Advance the predicted scan by one character and return its flags.
    function automatic scan_result_t scan_char(input logic [CHAR_BITS-1:0] c, input logic eof);
        scan_result_t r;
        logic         again;
        int           t;
        r = '0;
        again = !eof;
        if (eof)
            r.done_res = 1'b1;
        while (again && !r.done_res)
        begin
            again = 1'b0;
            t = (scan_now.nest_level == 0) ? 0 : int'(scan_now.nest_level) - 1;
            if (t > NEST_LIMIT - 1)
                t = NEST_LIMIT - 1;
            case (scan_now.phase)
                PH_SKIP:
                    if (is_blank(c))
                        r.skipped = 1'b1;
                    else
                    begin
                        scan_now.phase = PH_CODE;
                        again = 1'b1;
                    end
                PH_CODE:
                    if (scan_now.code_depth == 0 && c == CH_RBRACE)
                    begin
                        r.done_res = 1'b1;
                        r.accepted = scan_now.seen_code;
                    end
                    else if (stop_cfg.stop_enable && scan_now.code_depth == 0
                             && scan_now.after_space_flag
                             && c == CHAR_BITS'(stop_cfg.stop_first_char))
                        scan_now.phase = PH_STOP1;
                    else if (is_blank(c))
                        scan_now.after_space_flag = 1'b1;
                    else
                    begin
                        scan_now.after_space_flag = 1'b0;
                        if (c == CH_SQUOTE || c == CH_DQUOTE)
                        begin
                            scan_now.quote_kind = (c == CH_SQUOTE) ? QK_SINGLE : QK_DOUBLE;
                            scan_now.string_in_hole = 1'b0;
                            scan_now.phase = PH_STRING;
                        end
                        else if (c == CH_BACKTICK)
                        begin
                            if (!open_template())
                            begin
                                r.done_res = 1'b1;
                                r.overflow = 1'b1;
                            end
                        end
                        else if (c == CH_SLASH)
                            scan_now.phase = PH_SLASH;
                        else if (c == CH_LBRACE && scan_now.code_depth >= DEPTH_MAX)
                        begin
                            r.done_res = 1'b1;
                            r.overflow = 1'b1;
                        end
                        else
                        begin
                            if (c == CH_LBRACE)
                                scan_now.code_depth = scan_now.code_depth + 1'b1;
                            else if (c == CH_RBRACE)
                                scan_now.code_depth = scan_now.code_depth - 1'b1;
                            r.mark_after = 1'b1;
                            scan_now.seen_code = 1'b1;
                        end
                    end
                PH_STOP1, PH_STOP2:
                    if (scan_now.phase == PH_STOP1
                        && c == CHAR_BITS'(stop_cfg.stop_second_char))
                        scan_now.phase = PH_STOP2;
                    else if (scan_now.phase == PH_STOP2 && (is_blank(c) || c == CH_RBRACE))
                    begin
                        r.done_res = 1'b1;
                        r.accepted = scan_now.seen_code;
                    end
                    else
                    begin
                        // broken stop word: mark before and rescan as code
                        r.mark_before = 1'b1;
                        scan_now.seen_code = 1'b1;
                        scan_now.after_space_flag = 1'b0;
                        scan_now.phase = PH_CODE;
                        again = 1'b1;
                    end
                PH_STRING:
                    if (c == CH_BACKSLASH)
                        scan_now.phase = PH_STRING_ESC;
                    else if ((scan_now.quote_kind == QK_SINGLE && c == CH_SQUOTE)
                             || (scan_now.quote_kind == QK_DOUBLE && c == CH_DQUOTE))
                    begin
                        if (scan_now.string_in_hole)
                            scan_now.phase = PH_HOLE;
                        else
                        begin
                            scan_now.phase = PH_CODE;
                            r.mark_after = 1'b1;
                            scan_now.seen_code = 1'b1;
                        end
                    end
                    else if (c == CH_NEWLINE)
                    begin
                        if (scan_now.string_in_hole)
                            scan_now.phase = PH_HOLE;
                        else
                        begin
                            scan_now.phase = PH_CODE;
                            r.mark_before = 1'b1;
                            scan_now.seen_code = 1'b1;
                        end
                        again = 1'b1;
                    end
                PH_STRING_ESC:
                    scan_now.phase = PH_STRING;
                PH_TMPL:
                    if (c == CH_BACKSLASH)
                        scan_now.phase = PH_TMPL_ESC;
                    else if (c == CH_BACKTICK)
                    begin
                        if (scan_now.nest_level != 0)
                            scan_now.nest_level = scan_now.nest_level - 1'b1;
                        if (scan_now.nest_level == 0)
                        begin
                            scan_now.phase = PH_CODE;
                            r.mark_after = 1'b1;
                            scan_now.seen_code = 1'b1;
                        end
                        else
                            scan_now.phase = PH_HOLE;
                    end
                    else if (c == CH_DOLLAR)
                        scan_now.phase = PH_TMPL_DOLLAR;
                PH_TMPL_ESC:
                    scan_now.phase = PH_TMPL;
                PH_TMPL_DOLLAR:
                    if (c == CH_LBRACE)
                    begin
                        scan_now.hole_depths[t] = DEPTH_BITS'(1);
                        scan_now.phase = PH_HOLE;
                    end
                    else
                    begin
                        scan_now.phase = PH_TMPL;
                        again = 1'b1;
                    end
                PH_HOLE:
                    if (c == CH_LBRACE)
                    begin
                        if (scan_now.hole_depths[t] >= DEPTH_MAX)
                        begin
                            r.done_res = 1'b1;
                            r.overflow = 1'b1;
                        end
                        else
                            scan_now.hole_depths[t] = scan_now.hole_depths[t] + 1'b1;
                    end
                    else if (c == CH_RBRACE)
                    begin
                        if (scan_now.hole_depths[t] != 0)
                            scan_now.hole_depths[t] = scan_now.hole_depths[t] - 1'b1;
                        if (scan_now.hole_depths[t] == 0)
                            scan_now.phase = PH_TMPL;
                    end
                    else if (c == CH_SQUOTE || c == CH_DQUOTE)
                    begin
                        scan_now.quote_kind = (c == CH_SQUOTE) ? QK_SINGLE : QK_DOUBLE;
                        scan_now.string_in_hole = 1'b1;
                        scan_now.phase = PH_STRING;
                    end
                    else if (c == CH_BACKTICK && !open_template())
                    begin
                        r.done_res = 1'b1;
                        r.overflow = 1'b1;
                    end
                PH_SLASH:
                    if (c == CH_SLASH)
                        scan_now.phase = PH_LINE;
                    else if (c == CH_STAR)
                        scan_now.phase = PH_BLOCK;
                    else
                    begin
                        r.mark_before = 1'b1;
                        scan_now.seen_code = 1'b1;
                        scan_now.phase = PH_CODE;
                        again = 1'b1;
                    end
                PH_LINE:
                    if (c == CH_NEWLINE)
                    begin
                        r.mark_before = 1'b1;
                        scan_now.seen_code = 1'b1;
                        scan_now.phase = PH_CODE;
                        again = 1'b1;
                    end
                PH_BLOCK:
                    if (c == CH_STAR)
                        scan_now.phase = PH_BLOCK_STAR;
                PH_BLOCK_STAR:
                    if (c == CH_SLASH)
                    begin
                        r.mark_after = 1'b1;
                        scan_now.seen_code = 1'b1;
                        scan_now.phase = PH_CODE;
                    end
                    else
                    begin
                        scan_now.phase = PH_BLOCK;
                        again = 1'b1;
                    end
                default:
                begin
                    scan_now.phase = PH_SKIP;
                    again = 1'b1;
                end
            endcase
        end
        if (r.done_res)
        begin
            scan_now = SCAN_CLEAR;
            r.skipped = 1'b0;
            if (eof || r.overflow)
            begin
                r.mark_before = 1'b0;
                r.mark_after = 1'b0;
                r.accepted = 1'b0;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_flags.push_back(scan_char(char_code, end_of_input));
    end

    function automatic void check_flag(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        scan_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_flags.size() == 0)
            begin
                $error("result transaction with no expected result pending");
                mismatches++;
            end
            else
            begin
                want = expected_flags.pop_front();
                check_flag("skipped", want.skipped, skipped);
                check_flag("mark_before", want.mark_before, mark_before);
                check_flag("mark_after", want.mark_after, mark_after);
                check_flag("done_res", want.done_res, done_res);
                check_flag("accepted", want.accepted, accepted);
                check_flag("overflow", want.overflow, overflow);
            end
        end
    end

    // receiver: long hold on request, otherwise a stall pattern that changes over time
    always @(posedge clk)
    begin
        rx_count <= rx_count + 1;
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_asked;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_count % 200 == 0)
                rx_mode <= rx_mode_e'($urandom_range(0, 3));
            case (rx_mode)
                RX_FREE:     out_stall <= 1'b0;
                RX_SPARSE:   out_stall <= ($urandom_range(0, 99) < 30);
                RX_PERIODIC: out_stall <= (rx_count % 7 < 3);
                default:     out_stall <= ($urandom_range(0, 99) < 70);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one character in bursts with random gaps; return once it is accepted.
    task send_char(input logic [CHAR_BITS-1:0] code, input logic eof);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 5) == 0) ? 15 : 4);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        char_code    <= code;
        end_of_input <= eof;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // '~' stands for a backtick
    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char((s[i] == "~") ? CH_BACKTICK : CHAR_BITS'(s[i]), 1'b0);
    endtask

    task wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_flags.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [STOP_BITS-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STOP_ENABLE: stop_cfg.stop_enable = data[0];
            CFG_STOP_FIRST:  stop_cfg.stop_first_char = data;
            CFG_STOP_SECOND: stop_cfg.stop_second_char = data;
            default: ;
        endcase
    endtask

    task set_stop(input logic [STOP_BITS-1:0] en, first, second);
        write_reg(CFG_STOP_ENABLE, en);
        write_reg(CFG_STOP_FIRST, first);
        write_reg(CFG_STOP_SECOND, second);
    endtask

    function automatic logic [CHAR_BITS-1:0] pick_word_char();
        string chars;
        chars = "abcdefghoqrsxyz0189+-=();.,:<>!&|?";
        return CHAR_BITS'(chars[$urandom_range(0, chars.len() - 1)]);
    endfunction

    function automatic logic [CHAR_BITS-1:0] pick_blank();
        if ($urandom_range(0, 1) == 0)
            return CH_SPACE;
        return CH_TAB + CHAR_BITS'($urandom_range(0, 4));
    endfunction

    function automatic logic [CHAR_BITS-1:0] pick_any_char();
        if ($urandom_range(0, 3) == 0)
            return CHAR_BITS'($urandom_range(0, 21'h1FFFFF));
        return CHAR_BITS'($urandom_range(0, 127));
    endfunction

    function automatic void add_string();
        logic [CHAR_BITS-1:0] q;
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        text.push_back(q);
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    text.push_back(CH_BACKSLASH);
                    text.push_back(pick_any_char());
                end
                1: text.push_back($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
                2: text.push_back((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
                3: text.push_back(CH_BACKTICK);
                default: text.push_back(pick_word_char());
            endcase
        end
        // an unclosed string ends at a newline
        text.push_back(($urandom_range(0, 9) == 0) ? CH_NEWLINE : q);
    endfunction

    function automatic void add_template(input int lvl);
        text.push_back(CH_BACKTICK);
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 4))
                0: text.push_back(pick_word_char());
                1:
                begin
                    text.push_back(CH_BACKSLASH);
                    text.push_back(pick_any_char());
                end
                2:
                begin
                    text.push_back(CH_DOLLAR);
                    text.push_back(pick_word_char());
                end
                default:
                begin
                    text.push_back(CH_DOLLAR);
                    text.push_back(CH_LBRACE);
                    add_code(lvl + 1, 1'b1);
                    text.push_back(CH_RBRACE);
                end
            endcase
        end
        text.push_back(CH_BACKTICK);
    endfunction

    // Append a run of code fragments; comments and stop words stay out of template holes.
    function automatic void add_code(input int lvl, input logic hole);
        fragment_e kind;
        repeat ($urandom_range(1, 5))
        begin
            kind = fragment_e'($urandom_range(0, 9));
            if (hole && (kind == FR_LINE_NOTE || kind == FR_BLOCK_NOTE || kind == FR_STOP_WORD))
                kind = FR_WORD;
            if (lvl >= 3 && (kind == FR_BRACES || kind == FR_TEMPLATE))
                kind = FR_WORD;
            case (kind)
                FR_BLANK: text.push_back(pick_blank());
                FR_BRACES:
                begin
                    text.push_back(CH_LBRACE);
                    add_code(lvl + 1, hole);
                    text.push_back(CH_RBRACE);
                end
                FR_STRING: add_string();
                FR_TEMPLATE: add_template(lvl);
                FR_LINE_NOTE:
                begin
                    text.push_back(CH_SLASH);
                    text.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 3))
                        text.push_back($urandom_range(0, 2) ? pick_word_char() : CH_RBRACE);
                    text.push_back(CH_NEWLINE);
                end
                FR_BLOCK_NOTE:
                begin
                    text.push_back(CH_SLASH);
                    text.push_back(CH_STAR);
                    repeat ($urandom_range(0, 4))
                    begin
                        case ($urandom_range(0, 3))
                            0: text.push_back(CH_STAR);
                            1: text.push_back(CH_RBRACE);
                            2: text.push_back(CH_SLASH);
                            default: text.push_back(pick_word_char());
                        endcase
                    end
                    text.push_back(CH_STAR);
                    text.push_back(CH_SLASH);
                end
                FR_WIDE: text.push_back(CHAR_BITS'($urandom_range(128, 21'h1FFFFF)));
                FR_STOP_WORD:
                begin
                    text.push_back(CH_SPACE);
                    text.push_back(CHAR_BITS'(stop_cfg.stop_first_char));
                    if ($urandom_range(0, 3) != 0)
                        text.push_back(CHAR_BITS'(stop_cfg.stop_second_char));
                    text.push_back($urandom_range(0, 1) ? pick_blank() : pick_word_char());
                end
                FR_SLASH:
                begin
                    text.push_back(CH_SLASH);
                    text.push_back(pick_word_char());
                end
                default:
                    repeat ($urandom_range(1, 4)) text.push_back(pick_word_char());
            endcase
        end
    endfunction

    // Build one scan of random text, mostly well formed, and send it.
    task run_scan();
        logic eof;
        int   ending;
        eof = 1'b0;
        text.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8)) text.push_back(pick_any_char());
        end
        else
        begin
            repeat ($urandom_range(0, 3)) text.push_back(pick_blank());
            add_code(0, 1'b0);
            ending = $urandom_range(0, 9);
            if (ending < 7)
                text.push_back(CH_RBRACE);
            else if (ending == 7 && stop_cfg.stop_enable)
            begin
                text.push_back(CH_SPACE);
                text.push_back(CHAR_BITS'(stop_cfg.stop_first_char));
                text.push_back(CHAR_BITS'(stop_cfg.stop_second_char));
                text.push_back($urandom_range(0, 1) ? CH_RBRACE : pick_blank());
            end
            else if (ending == 8)
                eof = 1'b1;
        end
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], 1'b0);
        if (eof)
            send_char(CHAR_BITS'($urandom_range(0, 21'h1FFFFF)), 1'b1);
        random_items += text.size() + int'(eof);
    endtask

    task test_empty_and_eof();
        send_text(" \t}");
        send_text("x");
        send_char(21'h1FFFFF, 1'b1);
        send_char(21'h1FFFFF, 1'b0);
        send_char(21'h110000, 1'b0);
        send_char('0, 1'b0);
        send_char(CH_RBRACE, 1'b0);
        send_char('0, 1'b1);
    endtask

    task test_quotes_and_comments();
        send_text("'}\\'\n\"{\\\"\"/x//}\n/*}**/}");
    endtask

    task test_templates();
        send_text("~${{}~}~}~}");
        send_text("~$x\\~}~}");
        send_text("~${'}\n}~}");
    endtask

    task test_stop_word();
        set_stop(7'h7F, 7'd111, 7'd102);
        send_text(" of}x of x ox}x o}");
        // stop word made of a blank and an opening brace
        set_stop(7'h01, 7'h20, 7'h7B);
        send_text("a  {}");
        set_stop(7'h01, 7'h00, 7'h7F);
        write_reg(CFG_UNUSED, 7'h7F);
        send_text("q ");
        send_char('0, 1'b0);
        send_char(21'h7F, 1'b0);
        send_char(CH_SPACE, 1'b0);
        write_reg(CFG_STOP_ENABLE, 7'h7E);
    endtask

    task test_nesting_bounds();
        send_text("a");
        repeat (256) send_char(CH_LBRACE, 1'b0);
        repeat (NEST_LIMIT) send_text("~${");
        send_text("~");
        send_text("~${");
        repeat (255) send_char(CH_LBRACE, 1'b0);
    endtask

    task test_random_text(input logic [STOP_BITS-1:0] en, first, second,
                          input int goal, input logic squeeze);
        int   start;
        logic squeezed;
        set_stop(en, first, second);
        start = random_items;
        squeezed = 1'b0;
        while (random_items - start < goal)
        begin
            // hold off the receiver while the sender keeps offering
            if (squeeze && !squeezed && random_items - start >= goal / 2)
            begin
                holds_asked++;
                squeezed = 1'b1;
            end
            run_scan();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_eof();
        test_quotes_and_comments();
        test_templates();
        test_stop_word();
        test_nesting_bounds();
        test_random_text(7'h00, 7'd111, 7'd102, 190, 1'b0);
        test_random_text(7'h01, 7'd111, 7'd102, 190, 1'b1);
        test_random_text(7'h01, 7'd98, 7'd121, 190, 1'b0);
        test_random_text(7'h01, 7'h20, 7'h7D, 190, 1'b0);
        test_random_text(7'h01, 7'h00, 7'h7F, 190, 1'b1);
        test_random_text(7'h01, STOP_BITS'($urandom_range(0, 127)),
                         STOP_BITS'($urandom_range(0, 127)), 190, 1'b0);
        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_flags.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
